### rtl/hbs_pkg.sv
// Shared types, constants and the quarter-cosine falloff table for the brush stamp block.
package hbs_pkg;

  localparam int MAX_SIDE_DEF = 256;
  localparam int LAYERS_DEF   = 4;
  localparam int COS_DEPTH    = 256;
  localparam int TI_W         = $clog2(COS_DEPTH + 1);
  localparam int WEIGHT_W     = 13;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 13'd4096;
  localparam logic [15:0]         FALL_ONE   = 16'd32768;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_SCULPT = 2'd2,
    MODE_PAINT  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_STRENGTH = 3'd0,
    REG_PAINT_STRENGTH  = 3'd1,
    REG_MAX_HEIGHT      = 3'd2,
    REG_GRID_WIDTH      = 3'd3,
    REG_GRID_DEPTH      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  cell_x;
    logic [7:0]  cell_z;
    logic [2:0]  target;
    logic [15:0] write_value;
    logic [15:0] center_x;
    logic [15:0] center_z;
    logic [9:0]  radius;
    logic        square_brush;
    logic        lower;
    logic [15:0] frame_time;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [13:0] cells_changed;
  } result_t;

  // Response of the falloff unit for one cell.
  typedef struct packed {
    logic        done;
    logic        skip;
    logic [15:0] fall;
  } fo_rsp_t;

  typedef logic [15:0] cos_tab_t [COS_DEPTH+1];

  // Unsigned 64-bit quotient by restoring long division, for table building.
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(pi/2 * i / COS_DEPTH) in Q1.15 by a seven-term series in Q2.30.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        tab;
    longint unsigned a;
    longint unsigned s;
    longint unsigned r;
    longint unsigned p;
    longint unsigned q;
    for (int i = 0; i <= COS_DEPTH; i++) begin
      a = div_u64(HALF_PI_Q30 * longint'(i), longint'(COS_DEPTH));
      s = (a * a) >> 30;
      r = Q30_ONE;
      for (int k = 6; k >= 1; k--) begin
        p = div_u64((s * r) >> 30, longint'((2 * k) * (2 * k - 1)));
        r = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      end
      q = (r + (64'd1 << 14)) >> 15;
      tab[i] = (q > 64'd32768) ? FALL_ONE : q[15:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

### rtl/hbs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hbs_falloff.sv
// Per-cell brush falloff: distance test, iterative square root and divide, cosine lookup.
module hbs_falloff #(
  parameter int MAX_SIDE = hbs_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             square,
  input  logic [$clog2(MAX_SIDE+1)-1:0]    x,
  input  logic [$clog2(MAX_SIDE+1)-1:0]    z,
  input  logic [15:0]                      center_x,
  input  logic [15:0]                      center_z,
  input  logic [9:0]                       radius,
  output hbs_pkg::fo_rsp_t                 rsp
);
  import hbs_pkg::*;

  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int DW  = (SW + 9 > 17) ? SW + 9 : 17;
  localparam int AXW = DW - 1;
  localparam int SQW = 2 * AXW;
  localparam int NW  = 14 + TI_W;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUM, F_ROOT, F_DIVI, F_DIV, F_LOOK
  } fstate_t;

  fstate_t           state;
  logic [AXW-1:0]    ax;
  logic [AXW-1:0]    az;
  logic [SQW-1:0]    sx;
  logic [SQW-1:0]    sz;
  logic [13:0]       rq;
  logic [27:0]       r2;
  logic [27:0]       rad;
  logic [16:0]       rem;
  logic [13:0]       root;
  logic [NW-1:0]     num;
  logic [13:0]       drem;
  logic [TI_W-1:0]   q;
  logic [3:0]        cnt;

  logic [DW-1:0]     dx;
  logic [DW-1:0]     dz;
  logic [SQW:0]      d2;
  logic [16:0]       rem_sh;
  logic [16:0]       trial;
  logic [14:0]       dtry;

  always_comb begin
    dx     = DW'({x, 8'b0}) - DW'(center_x);
    dz     = DW'({z, 8'b0}) - DW'(center_z);
    d2     = (SQW+1)'(sx) + (SQW+1)'(sz);
    rem_sh = {rem[14:0], rad[27:26]};
    trial  = 17'({root, 2'b01});
    dtry   = {drem, num[TI_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      rsp.done <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (start && square) begin
            rq  <= {radius, 4'b0};
            rsp <= '{done: 1'b1, skip: 1'b0, fall: FALL_ONE};
          end else begin
            rsp.done <= 1'b0;
            if (start) begin
              rq    <= {radius, 4'b0};
              ax    <= dx[DW-1] ? AXW'(-dx) : dx[AXW-1:0];
              az    <= dz[DW-1] ? AXW'(-dz) : dz[AXW-1:0];
              state <= F_SQ;
            end
          end
        end
        F_SQ: begin
          sx    <= ax * ax;
          sz    <= az * az;
          r2    <= rq * rq;
          state <= F_SUM;
        end
        F_SUM: begin
          if (d2 > (SQW+1)'(r2)) begin
            rsp   <= '{done: 1'b1, skip: 1'b1, fall: 16'd0};
            state <= F_IDLE;
          end else begin
            rad   <= d2[27:0];
            rem   <= '0;
            root  <= '0;
            cnt   <= 4'd13;
            state <= F_ROOT;
          end
        end
        F_ROOT: begin
          // one result bit per step
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[12:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[12:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= F_DIVI;
          end
        end
        F_DIVI: begin
          num   <= NW'(root) * NW'(COS_DEPTH);
          drem  <= 14'((NW'(root) * NW'(COS_DEPTH)) >> TI_W);
          q     <= '0;
          cnt   <= 4'(TI_W - 1);
          state <= F_DIV;
        end
        F_DIV: begin
          // bring num's low TI_W bits in one at a time
          num <= {num[NW-2:0], 1'b0};
          if (dtry >= 15'(rq)) begin
            drem <= 14'(dtry - 15'(rq));
            q    <= {q[TI_W-2:0], 1'b1};
          end else begin
            drem <= dtry[13:0];
            q    <= {q[TI_W-2:0], 1'b0};
          end
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= F_LOOK;
          end
        end
        F_LOOK: begin
          rsp   <= '{done: 1'b1, skip: 1'b0, fall: COS_TAB[q]};
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/heightmap_brush_stamp.sv
// Top level of the terrain height and blend-weight brush stamp engine.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------
//  command  | start, transfer if !busy     | cmd (cmd_t)
//  result   | done, one-cycle strobe       | result (result_t)
//  config   | cfg_we, no wait              | cfg_index, cfg_wdata
//
// After reset the block sweeps both stores to zero, one cell per cycle, over all
// MAX_SIDE*MAX_SIDE cells (65536 by default); busy stays high meanwhile and
// config writes are still taken. A cell write or read steps through ST_CELL_ADDR,
// ST_CELL_RD and ST_CELL_WB. A stamp runs ST_SETUP, then per walked cell ST_ADDR,
// ST_FALL, ST_MUL1, ST_MUL2 and ST_UPDATE; a circle-brush cell waits in ST_FALL for
// the falloff unit's bit-per-cycle square root and table-index divide, and a cell
// outside the circle skips the multiplies and write-back. The receiver cannot stall: done pulses one cycle.
module heightmap_brush_stamp #(
  parameter int MAX_SIDE = hbs_pkg::MAX_SIDE_DEF,
  parameter int LAYERS   = hbs_pkg::LAYERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  hbs_pkg::cmd_t                 cmd,
  output logic                          busy,
  output logic                          done,
  output hbs_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_wdata
);
  import hbs_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int WW    = LAYERS * WEIGHT_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CELL_ADDR, ST_CELL_RD, ST_CELL_WB,
    ST_SETUP, ST_ADDR, ST_FALL, ST_MUL1, ST_MUL2, ST_UPDATE
  } state_t;

  state_t         state;
  cmd_t           cmd_r;
  logic [11:0]    height_strength;
  logic [7:0]     paint_strength;
  logic [15:0]    height_ceiling;
  logic [8:0]     grid_width;
  logic [8:0]     grid_depth;

  logic [AW-1:0]  clr_cnt;
  logic [AW-1:0]  addr;
  logic           cell_ok;
  logic [SW-1:0]  x, z, x0, x1, z1;
  logic [15:0]    fall;
  logic [27:0]    prod1;
  logic [43:0]    prod2;
  logic [13:0]    count;

  logic [SW-1:0]       w_side, d_side;
  logic [AW-1:0]       waddr;
  logic                h_we, w_we;
  logic [15:0]         h_wdata, h_rdata;
  logic [WW-1:0]       w_wdata, w_rdata;
  logic [WEIGHT_W-1:0] lane_cur, lane_new;
  logic                sculpt, layer_bad;
  logic [24:0]         amt;
  logic [25:0]         up_sum;
  logic [15:0]         h_new;
  logic [15:0]         wv_sat;
  logic [SW-1:0]       x_inc, z_inc;
  logic [13:0]         count_inc;
  logic [SW-1:0]       lo_x, hi_x, lo_z, hi_z;
  logic                active;
  fo_rsp_t             fo_rsp;

  // Clamp of the low edge: floor(ci - r), zero if negative, at most size.
  function automatic logic [SW-1:0] span_lo(input logic [15:0] c, input logic [9:0] r,
                                           input logic [SW-1:0] size);
    logic [12:0] c16;
    logic [12:0] l;
    c16 = {1'b0, c[15:8], 4'b0};
    if ({3'b0, r} > c16) begin
      return '0;
    end
    l = (c16 - {3'b0, r}) >> 4;
    if (32'(l) >= 32'(size)) begin
      return size;
    end
    return SW'(l);
  endfunction

  // High edge: floor(ci + r), saturated to size.
  function automatic logic [SW-1:0] span_hi(input logic [15:0] c, input logic [9:0] r,
                                           input logic [SW-1:0] size);
    logic [12:0] h;
    h = ({1'b0, c[15:8], 4'b0} + {3'b0, r}) >> 4;
    if (32'(h) >= 32'(size)) begin
      return size;
    end
    return SW'(h);
  endfunction

  // Grid sizes in use, saturated to [1, MAX_SIDE].
  always_comb begin
    if (32'(grid_width) > MAX_SIDE) w_side = SW'(MAX_SIDE);
    else if (grid_width == 9'd0)    w_side = SW'(1);
    else                            w_side = SW'(grid_width);
    if (32'(grid_depth) > MAX_SIDE) d_side = SW'(MAX_SIDE);
    else if (grid_depth == 9'd0)    d_side = SW'(1);
    else                            d_side = SW'(grid_depth);
  end

  assign busy   = (state != ST_IDLE);
  assign sculpt = (cmd_r.mode == MODE_SCULPT);
  assign layer_bad = (32'(cmd_r.target) > LAYERS);

  // Stamp rectangle and whether the stamp does anything at all.
  always_comb begin
    lo_x   = span_lo(cmd_r.center_x, cmd_r.radius, w_side);
    hi_x   = span_hi(cmd_r.center_x, cmd_r.radius, w_side);
    lo_z   = span_lo(cmd_r.center_z, cmd_r.radius, d_side);
    hi_z   = span_hi(cmd_r.center_z, cmd_r.radius, d_side);
    active = (cmd_r.radius != 10'd0) &&
             !(!sculpt && (cmd_r.square_brush || cmd_r.target == 3'd0 || layer_bad)) &&
             (lo_x < hi_x) && (lo_z < hi_z);
  end

  // Pick the addressed blend layer out of the weight word.
  always_comb begin
    lane_cur = '0;
    for (int l = 0; l < LAYERS; l++) begin
      if ({1'b0, cmd_r.target} == 4'(l + 1)) begin
        lane_cur = w_rdata[l*WEIGHT_W +: WEIGHT_W];
      end
    end
  end

  // Modify: sculpt or paint amount, then clamp.
  always_comb begin
    amt    = sculpt ? 25'(prod2 >> 25) : 25'(prod2 >> 19);
    up_sum = 26'(sculpt ? h_rdata : 16'(lane_cur)) + 26'(amt);
    if (sculpt) begin
      if (cmd_r.lower) h_new = (26'(h_rdata) > 26'(amt)) ? 16'(26'(h_rdata) - 26'(amt)) : '0;
      else             h_new = (up_sum >= 26'(height_ceiling)) ? height_ceiling
                                                               : up_sum[15:0];
      lane_new = lane_cur;
    end else begin
      h_new = h_rdata;
      if (cmd_r.lower) lane_new = (25'(lane_cur) > amt) ? WEIGHT_W'(25'(lane_cur) - amt) : '0;
      else             lane_new = (up_sum > 26'(WEIGHT_ONE)) ? WEIGHT_ONE : up_sum[WEIGHT_W-1:0];
    end
    wv_sat = (cmd_r.write_value > 16'(WEIGHT_ONE)) ? 16'(WEIGHT_ONE) : cmd_r.write_value;
  end

  // Store write port: clearing sweep, cell write, stamp write-back.
  always_comb begin
    waddr   = (state == ST_CLEAR) ? clr_cnt : addr;
    h_we    = 1'b0;
    w_we    = 1'b0;
    h_wdata = h_new;
    w_wdata = w_rdata;
    case (state)
      ST_CLEAR: begin
        h_we    = 1'b1;
        w_we    = 1'b1;
        h_wdata = '0;
        w_wdata = '0;
      end
      ST_CELL_WB: begin
        if (cmd_r.mode == MODE_WRITE && cell_ok) begin
          if (cmd_r.target == 3'd0) begin
            h_we    = 1'b1;
            h_wdata = cmd_r.write_value;
          end else begin
            w_we = 1'b1;
            for (int l = 0; l < LAYERS; l++) begin
              if ({1'b0, cmd_r.target} == 4'(l + 1)) begin
                w_wdata[l*WEIGHT_W +: WEIGHT_W] = wv_sat[WEIGHT_W-1:0];
              end
            end
          end
        end
      end
      ST_UPDATE: begin
        if (sculpt) begin
          h_we = 1'b1;
        end else begin
          w_we = 1'b1;
          for (int l = 0; l < LAYERS; l++) begin
            if ({1'b0, cmd_r.target} == 4'(l + 1)) begin
              w_wdata[l*WEIGHT_W +: WEIGHT_W] = lane_new;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign x_inc     = x + SW'(1);
  assign z_inc     = z + SW'(1);
  assign count_inc = (count == '1) ? count : count + 14'd1;

  hbs_ram #(.WIDTH(16), .DEPTH(CELLS)) u_height_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (waddr),
    .wdata (h_wdata),
    .raddr (addr),
    .rdata (h_rdata)
  );

  hbs_ram #(.WIDTH(WW), .DEPTH(CELLS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (waddr),
    .wdata (w_wdata),
    .raddr (addr),
    .rdata (w_rdata)
  );

  hbs_falloff #(.MAX_SIDE(MAX_SIDE)) u_falloff (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ADDR),
    .square   (cmd_r.square_brush),
    .x        (x),
    .z        (z),
    .center_x (cmd_r.center_x),
    .center_z (cmd_r.center_z),
    .radius   (cmd_r.radius),
    .rsp      (fo_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_cnt         <= '0;
      done            <= 1'b0;
      height_strength <= 12'd500;
      paint_strength  <= 8'd5;
      height_ceiling  <= 16'hFFFF;
      grid_width      <= 9'd256;
      grid_depth      <= 9'd256;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEIGHT_STRENGTH: height_strength <= cfg_wdata[11:0];
          REG_PAINT_STRENGTH:  paint_strength  <= cfg_wdata[7:0];
          REG_MAX_HEIGHT:      height_ceiling  <= cfg_wdata[15:0];
          REG_GRID_WIDTH:      grid_width      <= cfg_wdata[8:0];
          REG_GRID_DEPTH:      grid_depth      <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_CLEAR: begin
          // zero one cell of both stores per cycle
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // the result strobe, if any, lives only in the first idle cycle
          done <= 1'b0;
          if (start) begin
            cmd_r <= cmd;
            count <= '0;
            if (cmd.mode == MODE_WRITE || cmd.mode == MODE_READ) state <= ST_CELL_ADDR;
            else                                                  state <= ST_SETUP;
          end
        end
        ST_CELL_ADDR: begin
          addr    <= AW'(32'(cmd_r.cell_z) * 32'(w_side) + 32'(cmd_r.cell_x));
          cell_ok <= (32'(cmd_r.cell_x) < 32'(w_side)) &&
                     (32'(cmd_r.cell_z) < 32'(d_side)) && !layer_bad;
          state   <= ST_CELL_RD;
        end
        ST_CELL_RD: begin
          state <= ST_CELL_WB;
        end
        ST_CELL_WB: begin
          // read data is valid now; a write is done by the port logic
          done                 <= 1'b1;
          result.cells_changed <= '0;
          if (cmd_r.mode == MODE_READ && cell_ok) begin
            result.read_value <= (cmd_r.target == 3'd0) ? h_rdata : 16'(lane_cur);
          end else begin
            result.read_value <= '0;
          end
          state <= ST_IDLE;
        end
        ST_SETUP: begin
          x0 <= lo_x;
          x1 <= hi_x;
          z1 <= hi_z;
          x  <= lo_x;
          z  <= lo_z;
          if (active) begin
            state <= ST_ADDR;
          end else begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end
        end
        ST_ADDR: begin
          addr  <= AW'(32'(z) * 32'(w_side) + 32'(x));
          state <= ST_FALL;
        end
        ST_FALL: begin
          if (fo_rsp.done) begin
            fall <= fo_rsp.fall;
            if (!fo_rsp.skip) begin
              state <= ST_MUL1;
            end else if (x_inc != x1) begin
              x     <= x_inc;
              state <= ST_ADDR;
            end else if (z_inc != z1) begin
              x     <= x0;
              z     <= z_inc;
              state <= ST_ADDR;
            end else begin
              done                 <= 1'b1;
              result.read_value    <= '0;
              result.cells_changed <= count;
              state                <= ST_IDLE;
            end
          end
        end
        ST_MUL1: begin
          prod1 <= (sculpt ? height_strength : 12'(paint_strength)) * fall;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2 <= 44'(prod1) * 44'(cmd_r.frame_time);
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // write-back happens this cycle; advance to the next cell
          count <= count_inc;
          if (x_inc != x1) begin
            x     <= x_inc;
            state <= ST_ADDR;
          end else if (z_inc != z1) begin
            x     <= x0;
            z     <= z_inc;
            state <= ST_ADDR;
          end else begin
            done                 <= 1'b1;
            result.read_value    <= '0;
            result.cells_changed <= count_inc;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(h_we || w_we))
    else $error("store written while idle");

  a_falloff_expected: assert property (@(posedge clk) disable iff (rst)
    fo_rsp.done |-> (state == ST_FALL))
    else $error("falloff response outside the wait state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not start work");

endmodule

### tb/heightmap_brush_stamp_test.sv
// Self-checking testbench for the heightmap brush stamp engine.
module heightmap_brush_stamp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  // Predicts every result of the block from a private copy of both stores and
  // the register file; results are checked in order against that queue.
  class brush_scoreboard;
    bit [15:0]   height_mem [65536];
    bit [15:0]   weight_mem [65536][4];
    bit [15:0]   falloff_lut [COS_DEPTH+1];
    bit [11:0]   height_gain;
    bit [7:0]    paint_gain;
    bit [15:0]   height_cap;
    bit [8:0]    cols;
    bit [8:0]    rows;
    result_t     pending [$];
    int          errors;

    function new();
      longint unsigned ang, sq, acc, term, rnd;
      height_gain = 12'd500;
      paint_gain  = 8'd5;
      height_cap  = 16'hFFFF;
      cols        = 9'd256;
      rows        = 9'd256;
      errors      = 0;
      // Quarter cosine in Q1.15 from a seven-term series in Q2.30.
      for (int i = 0; i <= COS_DEPTH; i++) begin
        ang = (64'd1686629713 * longint'(i)) / COS_DEPTH;
        sq  = (ang * ang) >> 30;
        acc = 64'd1 << 30;
        for (int k = 6; k >= 1; k--) begin
          term = ((sq * acc) >> 30) / longint'((2 * k) * (2 * k - 1));
          acc  = (term >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
        end
        rnd = (acc + (64'd1 << 14)) >> 15;
        falloff_lut[i] = (rnd > 64'd32768) ? 16'd32768 : rnd[15:0];
      end
    endfunction

    function void set_reg(cfg_reg_t idx, bit [15:0] val);
      case (idx)
        REG_HEIGHT_STRENGTH: height_gain = val[11:0];
        REG_PAINT_STRENGTH:  paint_gain  = val[7:0];
        REG_MAX_HEIGHT:      height_cap  = val;
        REG_GRID_WIDTH:      cols        = val[8:0];
        REG_GRID_DEPTH:      rows        = val[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned side(bit [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return 32'(v);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v  -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Clamped walk range along one axis.
    function void span(int unsigned ctr, int unsigned rad, int unsigned size,
                       output int unsigned lo, output int unsigned hi);
      longint c16, l, h;
      c16 = longint'(ctr >> 8) * 16;
      l   = c16 - longint'(rad);
      h   = (c16 + longint'(rad)) / 16;
      lo  = (l < 0) ? 0 : 32'(l / 16);
      hi  = (h >= longint'(size)) ? size : 32'(h);
    endfunction

    // Note an accepted command: apply it to the stores, queue its result.
    function void note_command(cmd_t c);
      result_t         r;
      int unsigned     w, d, idx, x0, x1, z0, z1, cnt;
      longint unsigned rq, fall, amt, v, ax, az, d2, ti;
      longint          dx, dz;
      bit              paint, active;
      r   = '0;
      cnt = 0;
      w   = side(cols);
      d   = side(rows);
      if (c.mode == MODE_WRITE || c.mode == MODE_READ) begin
        if (c.cell_x < w && c.cell_z < d && c.target <= 4) begin
          idx = c.cell_z * w + c.cell_x;
          if (c.mode == MODE_WRITE) begin
            if (c.target == 0) height_mem[idx] = c.write_value;
            else weight_mem[idx][c.target-1] =
              (c.write_value > 16'd4096) ? 16'd4096 : c.write_value;
          end else begin
            r.read_value = (c.target == 0) ? height_mem[idx] : weight_mem[idx][c.target-1];
          end
        end
      end else begin
        paint  = (c.mode == MODE_PAINT);
        active = c.radius != 0 &&
                 !(paint && (c.square_brush || c.target == 0 || c.target > 4));
        if (active) begin
          rq = longint'(c.radius) * 16;
          span(c.center_x, c.radius, w, x0, x1);
          span(c.center_z, c.radius, d, z0, z1);
          for (int unsigned z = z0; z < z1; z++) begin
            for (int unsigned x = x0; x < x1; x++) begin
              idx  = z * w + x;
              fall = 32768;
              if (!c.square_brush) begin
                dx = longint'(x) * 256 - longint'(c.center_x);
                dz = longint'(z) * 256 - longint'(c.center_z);
                ax = (dx < 0) ? -dx : dx;
                az = (dz < 0) ? -dz : dz;
                d2 = ax * ax + az * az;
                if (d2 > rq * rq) continue;
                ti = root(d2) * COS_DEPTH / rq;
                if (ti > COS_DEPTH) ti = COS_DEPTH;
                fall = falloff_lut[ti];
              end
              if (!paint) begin
                amt = (longint'(height_gain) * fall * longint'(c.frame_time)) >> 25;
                v   = height_mem[idx];
                if (c.lower) v = (v > amt) ? v - amt : 0;
                else begin
                  v += amt;
                  if (v >= height_cap) v = height_cap;
                end
                height_mem[idx] = v[15:0];
              end else begin
                amt = (longint'(paint_gain) * fall * longint'(c.frame_time)) >> 19;
                v   = weight_mem[idx][c.target-1];
                if (c.lower) v = (v > amt) ? v - amt : 0;
                else begin
                  v += amt;
                  if (v > 4096) v = 4096;
                end
                weight_mem[idx][c.target-1] = v[15:0];
              end
              if (cnt < 16383) cnt++;
            end
          end
        end
        r.cells_changed = cnt[13:0];
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: read_value %0d cells_changed %0d",
               got.read_value, got.cells_changed);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value expected %0d actual %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.cells_changed !== want.cells_changed) begin
        $error("cells_changed expected %0d actual %0d", want.cells_changed,
               got.cells_changed);
        errors++;
      end
    endfunction
  endclass

  // Watchdog: cycles with no transfer on either side before giving up.
  // Covers the reset clearing sweep and the largest circle stamp.
  localparam int QUIET_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  cmd_t                 cmd;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  brush_scoreboard stamp_sb;
  bit              gaps_on;
  int              quiet_cycles;

  heightmap_brush_stamp DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Check each result strobe; count quiet cycles for the watchdog.
  always @(posedge clk) begin
    if (!rst && done) stamp_sb.check_result(result);
    if (rst || (start && !busy) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive one command; hold it until the block takes it. Optionally idle
  // first for a random burst. Inputs change only at the falling edge.
  task automatic send(cmd_t c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy);
    stamp_sb.note_command(c);
    @(negedge clk);
  endtask

  // Random filler for the fields a command does not use.
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c = cmd_t'(CMD_W'({$urandom, $urandom, $urandom, $urandom}));
    return c;
  endfunction

  task automatic send_cell(mode_t m, int x, int z, int tgt, int val);
    cmd_t c;
    c             = noise_cmd();
    c.mode        = m;
    c.cell_x      = 8'(x);
    c.cell_z      = 8'(z);
    c.target      = 3'(tgt);
    c.write_value = 16'(val);
    send(c);
  endtask

  task automatic send_stamp(mode_t m, int bx, int bz, int rad, bit sq, bit low,
                            int tgt, int ft);
    cmd_t c;
    c              = noise_cmd();
    c.mode         = m;
    c.center_x     = 16'(bx);
    c.center_z     = 16'(bz);
    c.radius       = 10'(rad);
    c.square_brush = sq;
    c.lower        = low;
    c.target       = 3'(tgt);
    c.frame_time   = 16'(ft);
    send(c);
  endtask

  // Release start and hold until every expected result has arrived.
  task automatic drain();
    start = 1'b0;
    while (stamp_sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(val);
    stamp_sb.set_reg(idx, 16'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(int hs, int ps, int mh, int gw, int gd);
    write_reg(REG_HEIGHT_STRENGTH, hs);
    write_reg(REG_PAINT_STRENGTH, ps);
    write_reg(REG_MAX_HEIGHT, mh);
    write_reg(REG_GRID_WIDTH, gw);
    write_reg(REG_GRID_DEPTH, gd);
  endtask

  // Random command focused on a small window near the grid origin so that
  // reads land on cells earlier stamps touched; some items roam freely.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned w, d, wx, wz;
    w  = stamp_sb.side(stamp_sb.cols);
    d  = stamp_sb.side(stamp_sb.rows);
    wx = (w < 20) ? w : 20;
    wz = (d < 20) ? d : 20;
    c  = noise_cmd();
    c.mode = mode_t'($urandom_range(0, 3));
    if ($urandom_range(0, 4) != 0) begin
      c.cell_x = 8'($urandom_range(0, wx - 1));
      c.cell_z = 8'($urandom_range(0, wz - 1));
    end
    if ($urandom_range(0, 6) != 0) c.target = 3'($urandom_range(0, 4));
    if ($urandom_range(0, 1) != 0) c.write_value = 16'($urandom_range(0, 4200));
    if ($urandom_range(0, 6) != 0) begin
      c.center_x = 16'(($urandom_range(0, wx) << 8) | $urandom_range(0, 255));
      c.center_z = 16'(($urandom_range(0, wz) << 8) | $urandom_range(0, 255));
    end
    // Keep walks short on a large grid; any radius on a small one.
    if (w * d <= 256) c.radius = 10'($urandom_range(0, 1023));
    else if ($urandom_range(0, 9) == 0) c.radius = 10'($urandom_range(0, 120));
    else c.radius = 10'($urandom_range(16, 64));
    return c;
  endfunction

  task automatic random_run(int n);
    repeat (n) send(random_cmd());
  endtask

  initial begin
    stamp_sb  = new();
    gaps_on   = 1'b1;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed part with reset register values.
    send_cell(MODE_WRITE, 0, 0, 0, 16'hFFFF);
    send_cell(MODE_READ, 0, 0, 0, 0);
    send_cell(MODE_WRITE, 255, 255, 0, 16'h1234);
    send_cell(MODE_READ, 255, 255, 0, 0);
    send_cell(MODE_WRITE, 3, 4, 1, 16'hFFFF);     // weight saturates to one
    send_cell(MODE_READ, 3, 4, 1, 0);
    send_cell(MODE_WRITE, 3, 4, 4, 100);
    send_cell(MODE_WRITE, 3, 4, 7, 777);          // target beyond layers: drop
    send_cell(MODE_READ, 3, 4, 5, 0);
    send_stamp(MODE_SCULPT, 3 << 8, 4 << 8, 16, 1'b0, 1'b0, 0, 16'hFFFF);
    send_cell(MODE_READ, 3, 4, 0, 0);
    send_stamp(MODE_SCULPT, 16'h0180, 16'h0100, 32, 1'b1, 1'b1, 0, 16'hFFFF);
    send_cell(MODE_READ, 0, 0, 0, 0);
    send_stamp(MODE_PAINT, 3 << 8, 4 << 8, 32, 1'b1, 1'b0, 2, 16'hFFFF); // square: no-op
    send_stamp(MODE_PAINT, 3 << 8, 4 << 8, 32, 1'b0, 1'b0, 0, 16'hFFFF); // height target
    send_stamp(MODE_PAINT, 16'h0340, 16'h0420, 48, 1'b0, 1'b0, 2, 16'hFFFF);
    send_stamp(MODE_PAINT, 16'h0340, 16'h0420, 40, 1'b0, 1'b1, 1, 16'h8000);
    send_cell(MODE_READ, 3, 4, 2, 0);
    send_stamp(MODE_SCULPT, 3 << 8, 4 << 8, 0, 1'b0, 1'b0, 0, 16'hFFFF);    // zero radius
    send_stamp(MODE_SCULPT, 16'hFFFF, 16'hFFFF, 800, 1'b1, 1'b0, 0, 16'hFFFF);
    send_stamp(MODE_SCULPT, 16'hFFFF, 16'hFFFF, 800, 1'b0, 1'b1, 0, 0);
    send_cell(MODE_READ, 255, 255, 0, 0);
    random_run(20);

    // Strong brushes, tight height cap, small grid; out-of-grid cells.
    drain();
    write_all(4095, 255, 1000, 16, 9);
    send_cell(MODE_WRITE, 16, 2, 0, 500);
    send_cell(MODE_READ, 2, 9, 0, 0);
    random_run(25);

    // Zero strength and cap; width below range, depth above it.
    drain();
    write_all(0, 0, 0, 0, 511);
    random_run(12);

    // Random strengths on the full grid; pause until the block is empty,
    // then finish with no idling.
    drain();
    write_all($urandom_range(0, 4095), $urandom_range(0, 255), 16'hFFFF, 256, 256);
    random_run(15);
    drain();
    gaps_on = 1'b0;
    random_run(15);

    drain();
    repeat (20) @(negedge clk);
    if (stamp_sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/hbs_pkg.sv
rtl/hbs_ram.sv
rtl/hbs_falloff.sv
rtl/heightmap_brush_stamp.sv
tb/heightmap_brush_stamp_test.sv
